// ----- rtl/rtcsc_pkg.sv -----
// Package with shared constants, codes and types for the RTC field/epoch seconds converter.
package rtcsc_pkg;

	// Number of register stages from input transfer to output register.
	localparam int NSTAGE = 9;

	// Calendar constants.
	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
	localparam logic [15:0] DAY_OFFSET    = 16'd10957;
	localparam logic [15:0] DAY_MAX       = 16'd16383;
	localparam logic [31:0] EPOCH_OFFSET_SECS = 32'(64'd10957 * 64'd86400);

	// Reciprocal constants for division by a constant. The quotient taken from
	// the product is low by at most one and is corrected by one compare.
	// The day divider works on seconds shifted right by 7 (86400 = 128 * 675).
	localparam int K_DAY  = 35;
	localparam logic [25:0] M_DAY  = 26'((64'd1 << K_DAY) / 64'd675);
	localparam int K_HOUR = 28;
	localparam logic [16:0] M_HOUR = 17'((64'd1 << K_HOUR) / 64'd3600);
	localparam int K_MIN  = 16;
	localparam logic [10:0] M_MIN  = 11'((64'd1 << K_MIN) / 64'd60);

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BEFORE_2000 = 2'd1,
		ST_OVERFLOW    = 2'd2
	} status_t;

	// Per-stage load enables from the pipeline control to the datapath.
	typedef struct packed {
		logic [NSTAGE-1:0] load;
	} pipe_ctrl_t;

endpackage

// ----- rtl/rtcsc_datapath.sv -----
// Pipelined datapath of the RTC field/epoch seconds converter.
module rtcsc_datapath import rtcsc_pkg::*; (
	input  logic        clk,
	input  pipe_ctrl_t  ctrl,
	input  logic        mode,
	input  logic [31:0] epoch_seconds,
	input  logic [6:0]  half_second_units,
	input  logic [5:0]  minute_in,
	input  logic [4:0]  hour_in,
	input  logic [13:0] day_in,
	output logic [31:0] seconds_out,
	output logic [6:0]  half_second_out,
	output logic [5:0]  minute_out,
	output logic [4:0]  hour_out,
	output logic [13:0] day_out,
	output logic [1:0]  status
);

	// Stage 1 registers.
	logic        mode_s1;
	logic [31:0] secs_s1;
	logic [30:0] pday_s1;
	logic [16:0] phr_s1;
	logic [11:0] pmin_s1;
	logic [5:0]  sec0_s1;
	logic [50:0] pq_s1;

	// Stage 2 registers.
	logic        mode_s2;
	logic [31:0] secs_s2;
	logic [31:0] suma_s2;
	logic [17:0] sumb_s2;
	logic [15:0] q0_s2;
	logic [31:0] qm_s2;

	// Stage 3 registers.
	logic        mode_s3;
	logic [31:0] seconds_s3;
	logic [15:0] whole_s3;
	logic [16:0] hms_s3;

	// Stage 4 registers.
	logic        mode_s4;
	logic [31:0] seconds_s4;
	status_t     st_s4;
	logic [13:0] day_s4;
	logic [16:0] hms_s4;
	logic [33:0] ph_s4;

	// Stage 5 registers.
	logic        mode_s5;
	logic [31:0] seconds_s5;
	status_t     st_s5;
	logic [13:0] day_s5;
	logic [16:0] hms_s5;
	logic [5:0]  h0_s5;
	logic [16:0] hm_s5;

	// Stage 6 registers.
	logic        mode_s6;
	logic [31:0] seconds_s6;
	status_t     st_s6;
	logic [13:0] day_s6;
	logic [4:0]  hour_s6;
	logic [11:0] rem_s6;

	// Stage 7 registers.
	logic        mode_s7;
	logic [31:0] seconds_s7;
	status_t     st_s7;
	logic [13:0] day_s7;
	logic [4:0]  hour_s7;
	logic [11:0] rem_s7;
	logic [22:0] pm_s7;

	// Stage 8 registers.
	logic        mode_s8;
	logic [31:0] seconds_s8;
	status_t     st_s8;
	logic [13:0] day_s8;
	logic [4:0]  hour_s8;
	logic [11:0] rem_s8;
	logic [6:0]  m0_s8;
	logic [11:0] mm_s8;

	// Stage 9 (output) registers.
	logic [31:0] seconds_s9;
	logic [6:0]  half_s9;
	logic [5:0]  minute_s9;
	logic [4:0]  hour_s9;
	logic [13:0] day_s9;
	status_t     st_s9;

	// Combinational helpers.
	logic [17:0] diff_day;
	logic [15:0] whole_fix;
	logic [16:0] hms_fix;
	logic [15:0] day_full;
	status_t     st_chk;
	logic [16:0] diff_hr;
	logic [4:0]  hour_fix;
	logic [11:0] rem_fix;
	logic [11:0] diff_min;
	logic [5:0]  minute_fix;
	logic [5:0]  sec_fix;

	// Stage 1: mode 0 products and the day reciprocal product for mode 1.
	always_ff @(posedge clk) begin
		if (ctrl.load[0]) begin
			mode_s1 <= mode;
			secs_s1 <= epoch_seconds;
			pday_s1 <= 31'(day_in) * 31'(SECS_PER_DAY);
			phr_s1  <= 17'(hour_in) * 17'(SECS_PER_HOUR);
			pmin_s1 <= 12'(minute_in) * 12'(SECS_PER_MIN);
			sec0_s1 <= half_second_units[6:1];
			pq_s1   <= 51'(epoch_seconds[31:7]) * 51'(M_DAY);
		end
	end

	// Stage 2: partial sums for mode 0, estimated day count times seconds per day.
	always_ff @(posedge clk) begin
		if (ctrl.load[1]) begin
			mode_s2 <= mode_s1;
			secs_s2 <= secs_s1;
			suma_s2 <= 32'(pday_s1) + EPOCH_OFFSET_SECS;
			sumb_s2 <= 18'(phr_s1) + 18'(pmin_s1) + 18'(sec0_s1);
			q0_s2   <= pq_s1[50:K_DAY];
			qm_s2   <= 32'(pq_s1[50:K_DAY]) * 32'(SECS_PER_DAY);
		end
	end

	// Correct the day estimate by one when the remainder reaches a full day.
	always_comb begin
		diff_day = 18'(secs_s2 - qm_s2);
		if (diff_day >= 18'(SECS_PER_DAY)) begin
			whole_fix = q0_s2 + 16'd1;
			hms_fix   = 17'(diff_day - 18'(SECS_PER_DAY));
		end else begin
			whole_fix = q0_s2;
			hms_fix   = 17'(diff_day);
		end
	end

	// Stage 3: final mode 0 sum, whole days and seconds within the day.
	always_ff @(posedge clk) begin
		if (ctrl.load[2]) begin
			mode_s3    <= mode_s2;
			seconds_s3 <= suma_s2 + 32'(sumb_s2);
			whole_s3   <= whole_fix;
			hms_s3     <= hms_fix;
		end
	end

	// Range check of the day count against the clock's 14-bit window.
	always_comb begin
		day_full = whole_s3 - DAY_OFFSET;
		if (whole_s3 < DAY_OFFSET) begin
			st_chk = ST_BEFORE_2000;
		end else if (day_full > DAY_MAX) begin
			st_chk = ST_OVERFLOW;
		end else begin
			st_chk = ST_OK;
		end
	end

	// Stage 4: status, day field and the hour reciprocal product.
	always_ff @(posedge clk) begin
		if (ctrl.load[3]) begin
			mode_s4    <= mode_s3;
			seconds_s4 <= seconds_s3;
			st_s4      <= st_chk;
			day_s4     <= day_full[13:0];
			hms_s4     <= hms_s3;
			ph_s4      <= 34'(hms_s3) * 34'(M_HOUR);
		end
	end

	// Stage 5: estimated hour times seconds per hour.
	always_ff @(posedge clk) begin
		if (ctrl.load[4]) begin
			mode_s5    <= mode_s4;
			seconds_s5 <= seconds_s4;
			st_s5      <= st_s4;
			day_s5     <= day_s4;
			hms_s5     <= hms_s4;
			h0_s5      <= ph_s4[33:K_HOUR];
			hm_s5      <= 17'(ph_s4[33:K_HOUR]) * 17'(SECS_PER_HOUR);
		end
	end

	// Correct the hour estimate and form the seconds within the hour.
	always_comb begin
		diff_hr = hms_s5 - hm_s5;
		if (diff_hr >= 17'(SECS_PER_HOUR)) begin
			hour_fix = 5'(h0_s5 + 6'd1);
			rem_fix  = 12'(diff_hr - 17'(SECS_PER_HOUR));
		end else begin
			hour_fix = 5'(h0_s5);
			rem_fix  = 12'(diff_hr);
		end
	end

	// Stage 6: hour field and seconds within the hour.
	always_ff @(posedge clk) begin
		if (ctrl.load[5]) begin
			mode_s6    <= mode_s5;
			seconds_s6 <= seconds_s5;
			st_s6      <= st_s5;
			day_s6     <= day_s5;
			hour_s6    <= hour_fix;
			rem_s6     <= rem_fix;
		end
	end

	// Stage 7: minute reciprocal product.
	always_ff @(posedge clk) begin
		if (ctrl.load[6]) begin
			mode_s7    <= mode_s6;
			seconds_s7 <= seconds_s6;
			st_s7      <= st_s6;
			day_s7     <= day_s6;
			hour_s7    <= hour_s6;
			rem_s7     <= rem_s6;
			pm_s7      <= 23'(rem_s6) * 23'(M_MIN);
		end
	end

	// Stage 8: estimated minute times sixty.
	always_ff @(posedge clk) begin
		if (ctrl.load[7]) begin
			mode_s8    <= mode_s7;
			seconds_s8 <= seconds_s7;
			st_s8      <= st_s7;
			day_s8     <= day_s7;
			hour_s8    <= hour_s7;
			rem_s8     <= rem_s7;
			m0_s8      <= pm_s7[22:K_MIN];
			mm_s8      <= 12'(pm_s7[22:K_MIN]) * 12'(SECS_PER_MIN);
		end
	end

	// Correct the minute estimate and form the second within the minute.
	always_comb begin
		diff_min = rem_s8 - mm_s8;
		if (diff_min >= 12'(SECS_PER_MIN)) begin
			minute_fix = 6'(m0_s8 + 7'd1);
			sec_fix    = 6'(diff_min - 12'(SECS_PER_MIN));
		end else begin
			minute_fix = 6'(m0_s8);
			sec_fix    = 6'(diff_min);
		end
	end

	// Stage 9: select the result fields by mode and status.
	always_ff @(posedge clk) begin
		if (ctrl.load[8]) begin
			if (!mode_s8) begin
				seconds_s9 <= seconds_s8;
				half_s9    <= '0;
				minute_s9  <= '0;
				hour_s9    <= '0;
				day_s9     <= '0;
				st_s9      <= ST_OK;
			end else if (st_s8 != ST_OK) begin
				seconds_s9 <= '0;
				half_s9    <= '0;
				minute_s9  <= '0;
				hour_s9    <= '0;
				day_s9     <= '0;
				st_s9      <= st_s8;
			end else begin
				seconds_s9 <= '0;
				half_s9    <= {sec_fix, 1'b0};
				minute_s9  <= minute_fix;
				hour_s9    <= hour_s8;
				day_s9     <= day_s8;
				st_s9      <= ST_OK;
			end
		end
	end

	// Output fields come straight from the last stage.
	assign seconds_out     = seconds_s9;
	assign half_second_out = half_s9;
	assign minute_out      = minute_s9;
	assign hour_out        = hour_s9;
	assign day_out         = day_s9;
	assign status          = st_s9;

endmodule

// ----- rtl/rtc_fields_seconds_convert_top.sv -----
// Top level of the RTC field/epoch seconds converter: handshake and pipeline control.
//
// Converts between RTC register fields (half seconds, minute, hour and a 14-bit
// day count from 1 January 2000) and a 32-bit count of seconds since 1970.
// With mode low the fields are combined into seconds_out; with mode high
// epoch_seconds is split into fields and status flags a time before 2000 or a
// day count beyond the 14-bit range (other fields then read zero).
// Both channels use valid/stall: a transfer happens at a rising edge with
// valid high and stall low. Every input transfer gives exactly one output
// transfer, in order.
// Items pass the nine stage registers from input transfer to output valid;
// one item can be taken every cycle while in_stall is low. The stages follow the
// constant divisions by 86400, 3600 and 60 (reciprocal, back multiply, correction).
// When the receiver stalls, the output holds and items behind it close up
// into empty stages; in_stall rises only once every stage holds an item.
// Reset (arst_n low) empties the pipeline at once; no item is in flight after it.
module rtc_fields_seconds_convert_top import rtcsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [31:0] epoch_seconds,
	input  logic [6:0]  half_second_units,
	input  logic [5:0]  minute_in,
	input  logic [4:0]  hour_in,
	input  logic [13:0] day_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] seconds_out,
	output logic [6:0]  half_second_out,
	output logic [5:0]  minute_out,
	output logic [4:0]  hour_out,
	output logic [13:0] day_out,
	output logic [1:0]  status
);

	logic [NSTAGE-1:0] vld_q;
	logic [NSTAGE-1:0] vld_in;
	logic [NSTAGE-1:0] ready;
	pipe_ctrl_t        ctrl;

	// Each stage may take a new item when it is empty or its content moves on.
	always_comb begin
		ready[NSTAGE-1] = !vld_q[NSTAGE-1] || !out_stall;
		for (int k = NSTAGE - 2; k >= 0; k--) begin
			ready[k] = !vld_q[k] || ready[k+1];
		end
	end

	assign vld_in    = {vld_q[NSTAGE-2:0], in_valid};
	assign ctrl.load = ready & vld_in;
	assign in_stall  = !ready[0];
	assign out_valid = vld_q[NSTAGE-1];

	// Valid bits travel with the data through the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NSTAGE; k++) begin
				if (ready[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	rtcsc_datapath u_datapath (
		.clk               (clk),
		.ctrl              (ctrl),
		.mode              (mode),
		.epoch_seconds     (epoch_seconds),
		.half_second_units (half_second_units),
		.minute_in         (minute_in),
		.hour_in           (hour_in),
		.day_in            (day_in),
		.seconds_out       (seconds_out),
		.half_second_out   (half_second_out),
		.minute_out        (minute_out),
		.hour_out          (hour_out),
		.day_out           (day_out),
		.status            (status)
	);

`ifndef ASSERT_OFF
	// An accepted item always lands in the first stage.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[0])
		else $error("accepted item did not enter the first stage");

	// The input only stalls when the whole pipeline is full.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld_q))
		else $error("input stalled while a stage was empty");

	// An error status comes with all other fields zero.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |->
		(seconds_out == '0 && half_second_out == '0 && minute_out == '0 &&
		 hour_out == '0 && day_out == '0))
		else $error("error result with nonzero fields");

	// Split time fields stay within their calendar ranges.
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hour_out <= 5'd23 && minute_out <= 6'd59 &&
		half_second_out <= 7'd118 && half_second_out[0] == 1'b0))
		else $error("time field out of range");
`endif

endmodule

// ----- dv/rtc_fields_seconds_convert_top_test.sv -----
// Self-checking testbench for the RTC field and epoch seconds converter.
module rtc_fields_seconds_convert_top_test import rtcsc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// Conversion direction codes.
	localparam logic MODE_TO_SECONDS = 1'b0;
	localparam logic MODE_TO_FIELDS  = 1'b1;

	// Calendar figures used by the predictor.
	localparam longint unsigned DAYS_1970_TO_2000 = 64'd10957;
	localparam longint unsigned SECONDS_PER_DAY   = 64'd86400;
	localparam longint unsigned SECONDS_PER_HOUR  = 64'd3600;
	localparam longint unsigned SECONDS_PER_MIN   = 64'd60;
	localparam longint unsigned LAST_CLOCK_DAY    = 64'd16383;

	// First and last epoch second that the 14-bit day count can hold.
	localparam logic [31:0] FIRST_CLOCK_EPOCH = 32'd946684800;
	localparam logic [31:0] LAST_CLOCK_EPOCH  = 32'd2362262399;

	localparam bit TYPED_RESULT     = 1'b1;
	localparam bit PREDICTED_RESULT = 1'b0;

	localparam int RANDOM_PER_PHASE  = 240;
	localparam int LONG_HOLD_CYCLES  = 60;
	localparam int STALL_LIMIT       = 2000;
	localparam int NUM_DIRECTED      = 16;

	typedef struct packed {
		logic        mode;
		logic [31:0] epoch;
		logic [6:0]  half;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [13:0] day;
	} conv_req_t;

	typedef struct packed {
		logic [31:0] seconds;
		logic [6:0]  half;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [13:0] day;
		status_t     st;
	} conv_res_t;

	typedef struct packed {
		conv_req_t req;
		bit        typed;
		conv_res_t res;
	} conv_row_t;

	localparam conv_res_t NO_RESULT = '0;

	// Directed cases: boundaries of both conversions, error codes, ignored fields.
	localparam conv_row_t directed_table [NUM_DIRECTED] = '{
		'{'{MODE_TO_SECONDS, 32'd0, 7'd0, 6'd0, 5'd0, 14'd0}, TYPED_RESULT,
			'{32'd946684800, 7'd0, 6'd0, 5'd0, 14'd0, ST_OK}},
		'{'{MODE_TO_SECONDS, 32'd0, 7'd119, 6'd59, 5'd23, 14'd16383}, TYPED_RESULT,
			'{32'd2362262399, 7'd0, 6'd0, 5'd0, 14'd0, ST_OK}},
		'{'{MODE_TO_SECONDS, 32'd0, 7'd127, 6'd63, 5'd31, 14'd16383}, PREDICTED_RESULT,
			NO_RESULT},
		'{'{MODE_TO_SECONDS, 32'd0, 7'd1, 6'd0, 5'd0, 14'd0}, TYPED_RESULT,
			'{32'd946684800, 7'd0, 6'd0, 5'd0, 14'd0, ST_OK}},
		'{'{MODE_TO_SECONDS, 32'd0, 7'd118, 6'd0, 5'd0, 14'd1}, PREDICTED_RESULT,
			NO_RESULT},
		'{'{MODE_TO_FIELDS, 32'd0, 7'd0, 6'd0, 5'd0, 14'd0}, TYPED_RESULT,
			'{32'd0, 7'd0, 6'd0, 5'd0, 14'd0, ST_BEFORE_2000}},
		'{'{MODE_TO_FIELDS, 32'd946684799, 7'd0, 6'd0, 5'd0, 14'd0}, TYPED_RESULT,
			'{32'd0, 7'd0, 6'd0, 5'd0, 14'd0, ST_BEFORE_2000}},
		'{'{MODE_TO_FIELDS, 32'd946684800, 7'd0, 6'd0, 5'd0, 14'd0}, TYPED_RESULT,
			'{32'd0, 7'd0, 6'd0, 5'd0, 14'd0, ST_OK}},
		'{'{MODE_TO_FIELDS, 32'd946684801, 7'd0, 6'd0, 5'd0, 14'd0}, PREDICTED_RESULT,
			NO_RESULT},
		'{'{MODE_TO_FIELDS, 32'd2362262399, 7'd0, 6'd0, 5'd0, 14'd0}, TYPED_RESULT,
			'{32'd0, 7'd118, 6'd59, 5'd23, 14'd16383, ST_OK}},
		'{'{MODE_TO_FIELDS, 32'd2362262400, 7'd0, 6'd0, 5'd0, 14'd0}, TYPED_RESULT,
			'{32'd0, 7'd0, 6'd0, 5'd0, 14'd0, ST_OVERFLOW}},
		'{'{MODE_TO_FIELDS, 32'hFFFFFFFF, 7'd0, 6'd0, 5'd0, 14'd0}, TYPED_RESULT,
			'{32'd0, 7'd0, 6'd0, 5'd0, 14'd0, ST_OVERFLOW}},
		'{'{MODE_TO_FIELDS, 32'd1234567890, 7'd127, 6'd63, 5'd31, 14'd16383},
			PREDICTED_RESULT, NO_RESULT},
		'{'{MODE_TO_SECONDS, 32'hFFFFFFFF, 7'd61, 6'd30, 5'd12, 14'd8000},
			PREDICTED_RESULT, NO_RESULT},
		'{'{MODE_TO_FIELDS, 32'd1700000000, 7'd0, 6'd0, 5'd0, 14'd0}, PREDICTED_RESULT,
			NO_RESULT},
		'{'{MODE_TO_SECONDS, 32'd0, 7'h55, 6'h2A, 5'h15, 14'h2AAA}, PREDICTED_RESULT,
			NO_RESULT}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        mode = 1'b0;
	logic [31:0] epoch_seconds = '0;
	logic [6:0]  half_second_units = '0;
	logic [5:0]  minute_in = '0;
	logic [4:0]  hour_in = '0;
	logic [13:0] day_in = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] seconds_out;
	logic [6:0]  half_second_out;
	logic [5:0]  minute_out;
	logic [4:0]  hour_out;
	logic [13:0] day_out;
	logic [1:0]  status;

	conv_res_t pending_results [$];
	int        error_count = 0;
	int        quiet_cycles = 0;
	int        send_idle_pct = 15;
	int        recv_idle_pct = 53;
	int        hold_cycles_left = 0;

	rtc_fields_seconds_convert_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.epoch_seconds(epoch_seconds),
		.half_second_units(half_second_units),
		.minute_in(minute_in),
		.hour_in(hour_in),
		.day_in(day_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.seconds_out(seconds_out),
		.half_second_out(half_second_out),
		.minute_out(minute_out),
		.hour_out(hour_out),
		.day_out(day_out),
		.status(status)
	);

	always #5 clk = ~clk;

	// Computes the converter's result for one request.
	function automatic conv_res_t predict_conversion(conv_req_t r);
		conv_res_t       res;
		longint unsigned total;
		longint unsigned whole_days;
		longint unsigned day_secs;
		res = '0;
		res.st = ST_OK;
		if (r.mode == MODE_TO_SECONDS) begin
			total = longint'(r.day) + DAYS_1970_TO_2000;
			total = total * 24 + r.hour;
			total = total * 60 + r.minute;
			total = total * 60 + (r.half >> 1);
			res.seconds = total[31:0];
		end else begin
			whole_days = r.epoch / SECONDS_PER_DAY;
			day_secs = r.epoch % SECONDS_PER_DAY;
			if (whole_days < DAYS_1970_TO_2000) begin
				res.st = ST_BEFORE_2000;
			end else if (whole_days - DAYS_1970_TO_2000 > LAST_CLOCK_DAY) begin
				res.st = ST_OVERFLOW;
			end else begin
				res.day = 14'(whole_days - DAYS_1970_TO_2000);
				res.hour = 5'(day_secs / SECONDS_PER_HOUR);
				res.minute = 6'((day_secs % SECONDS_PER_HOUR) / SECONDS_PER_MIN);
				res.half = 7'((day_secs % SECONDS_PER_MIN) * 2);
			end
		end
		return res;
	endfunction

	// Random request: mostly legal clock fields and epochs the clock can hold,
	// with day-range edges and fully random bit patterns mixed in.
	function automatic conv_req_t random_request();
		conv_req_t r;
		int        pick;
		r.mode = 1'($urandom_range(1));
		r.epoch = $urandom;
		r.half = 7'($urandom);
		r.minute = 6'($urandom);
		r.hour = 5'($urandom);
		r.day = 14'($urandom);
		pick = $urandom_range(99);
		if (r.mode == MODE_TO_SECONDS) begin
			if (pick < 75) begin
				r.half = 7'($urandom_range(119));
				r.minute = 6'($urandom_range(59));
				r.hour = 5'($urandom_range(23));
			end
		end else begin
			if (pick < 65)
				r.epoch = $urandom_range(LAST_CLOCK_EPOCH, FIRST_CLOCK_EPOCH);
			else if (pick < 75)
				r.epoch = 32'(FIRST_CLOCK_EPOCH + $urandom_range(8) - 4);
			else if (pick < 85)
				r.epoch = 32'(LAST_CLOCK_EPOCH + $urandom_range(8) - 4);
		end
		return r;
	endfunction

	// Offers one request, with random gaps, and records its expected result
	// once the transfer has happened.
	task automatic send_conversion(conv_req_t r, bit typed, conv_res_t typed_res);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= r.mode;
		epoch_seconds <= r.epoch;
		half_second_units <= r.half;
		minute_in <= r.minute;
		hour_in <= r.hour;
		day_in <= r.day;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(typed ? typed_res : predict_conversion(r));
	endtask

	// Changes idling rates between clock edges so no edge sees a half-applied setting.
	task automatic set_idling(int send_pct, int recv_pct, int hold_cycles);
		in_valid <= 1'b0;
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		hold_cycles_left = hold_cycles;
		@(posedge clk);
	endtask

	function automatic void check_field(string name, logic [31:0] expected_value,
		logic [31:0] actual_value);
		if (actual_value !== expected_value) begin
			$error("%s: expected %0d, got %0d", name, expected_value, actual_value);
			error_count++;
		end
	endfunction

	// Receiver: random stalls, or a long hold-off counted down here.
	always @(posedge clk) begin
		if (hold_cycles_left > 0) begin
			out_stall <= 1'b1;
			hold_cycles_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Result checking and the no-progress watchdog.
	always @(posedge clk) begin
		conv_res_t exp;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result transfer: seconds_out %0d, status %0d",
						seconds_out, status);
					error_count++;
				end else begin
					exp = pending_results.pop_front();
					check_field("seconds_out", exp.seconds, seconds_out);
					check_field("half_second_out", 32'(exp.half), 32'(half_second_out));
					check_field("minute_out", 32'(exp.minute), 32'(minute_out));
					check_field("hour_out", 32'(exp.hour), 32'(hour_out));
					check_field("day_out", 32'(exp.day), 32'(day_out));
					check_field("status", 32'(exp.st), 32'(status));
				end
			end
		end
	end

	// Stimulus sequence.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cases, then random traffic with the sender idling lightly.
		foreach (directed_table[i])
			send_conversion(directed_table[i].req, directed_table[i].typed,
				directed_table[i].res);
		repeat (RANDOM_PER_PHASE)
			send_conversion(random_request(), PREDICTED_RESULT, NO_RESULT);

		// Receiver idles lightly, sender heavily.
		set_idling(53, 15, 0);
		repeat (RANDOM_PER_PHASE)
			send_conversion(random_request(), PREDICTED_RESULT, NO_RESULT);

		// No idling; starts with a long receiver hold-off so the pipeline fills.
		set_idling(0, 0, LONG_HOLD_CYCLES);
		repeat (RANDOM_PER_PHASE)
			send_conversion(random_request(), PREDICTED_RESULT, NO_RESULT);
		in_valid <= 1'b0;

		// Drain, then watch a little longer for stray transfers.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2 * NSTAGE) @(posedge clk);

		if (error_count == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/rtcsc_pkg.sv
rtl/rtcsc_datapath.sv
rtl/rtc_fields_seconds_convert_top.sv
dv/rtc_fields_seconds_convert_top_test.sv
